>>> rtl/gfp_pkg.sv
`timescale 1ns / 1ps

package gfp_pkg;

	localparam int MAX_DEGREE = 16;
	localparam int MIN_DEGREE = 2;
	localparam int DEG_W      = 5;
	localparam int ELEM_W     = 16;
	localparam int EXP_W      = 31;
	localparam int POLY_W     = ELEM_W + 1;
	localparam int DIGIT_W    = 8;
	localparam int PC_W       = 4;

	localparam logic [DEG_W-1:0] DEG_RESET  = 5'd8;
	localparam logic [DEG_W-1:0] DEG_NARROW = 5'(DIGIT_W);

	typedef logic [ELEM_W-1:0]  elem_t;
	typedef logic [EXP_W-1:0]   exp_t;
	typedef logic [POLY_W-1:0]  poly_t;
	typedef logic [DEG_W-1:0]   deg_t;
	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [PC_W-1:0]    pc_t;
	typedef logic [3:0]         op_t;
	typedef logic [3:0]         cond_t;

	// datapath operations
	localparam op_t OP_NOP    = 4'd0;
	localparam op_t OP_LOAD   = 4'd1;
	localparam op_t OP_XRES   = 4'd2;
	localparam op_t OP_FOLD   = 4'd3;
	localparam op_t OP_FIX    = 4'd4;
	localparam op_t OP_MUL_LO = 4'd5;
	localparam op_t OP_MUL_HI = 4'd6;
	localparam op_t OP_SHIFT  = 4'd7;
	localparam op_t OP_EMIT   = 4'd8;

	// jump conditions
	localparam cond_t C_NEVER       = 4'd0;
	localparam cond_t C_ALWAYS      = 4'd1;
	localparam cond_t C_NO_REQ      = 4'd2;
	localparam cond_t C_E_ZERO      = 4'd3;
	localparam cond_t C_X_ZERO      = 4'd4;
	localparam cond_t C_E_WIDE      = 4'd5;
	localparam cond_t C_BIT0_CLR    = 4'd6;
	localparam cond_t C_NARROW      = 4'd7;
	localparam cond_t C_E_LAST      = 4'd8;
	localparam cond_t C_OUT_BLOCKED = 4'd9;

	// program steps
	localparam pc_t ST_IDLE  = 4'd0;
	localparam pc_t ST_EZ    = 4'd1;
	localparam pc_t ST_XZ    = 4'd2;
	localparam pc_t ST_FOLD  = 4'd3;
	localparam pc_t ST_FIX   = 4'd4;
	localparam pc_t ST_CHK   = 4'd5;
	localparam pc_t ST_BIT   = 4'd6;
	localparam pc_t ST_MR_LO = 4'd7;
	localparam pc_t ST_MR_HI = 4'd8;
	localparam pc_t ST_SHIFT = 4'd9;
	localparam pc_t ST_MS_LO = 4'd10;
	localparam pc_t ST_MS_HI = 4'd11;
	localparam pc_t ST_FIN   = 4'd12;
	localparam pc_t PROG_LAST = ST_FIN;

	typedef struct packed {
		op_t   op;
		logic  dst_sq;
		cond_t cond;
		pc_t   target;
	} ucode_t;

	typedef struct packed {
		op_t  op;
		logic dst_sq;
	} ctl_t;

	typedef struct packed {
		logic e_zero;
		logic x_zero;
		logic e_wide;
		logic bit0_clr;
		logic e_last;
		logic narrow;
		logic out_blocked;
	} stat_t;

	function automatic ucode_t ucode(input pc_t pc);
		ucode_t u;
		u = '{op: OP_NOP, dst_sq: 1'b0, cond: C_NEVER, target: ST_IDLE};
		case (pc)
			ST_IDLE:  u = '{op: OP_LOAD,   dst_sq: 1'b0, cond: C_NO_REQ,      target: ST_IDLE};
			ST_EZ:    u = '{op: OP_NOP,    dst_sq: 1'b0, cond: C_E_ZERO,      target: ST_FIN};
			ST_XZ:    u = '{op: OP_XRES,   dst_sq: 1'b0, cond: C_X_ZERO,      target: ST_FIN};
			ST_FOLD:  u = '{op: OP_FOLD,   dst_sq: 1'b0, cond: C_E_WIDE,      target: ST_FOLD};
			ST_FIX:   u = '{op: OP_FIX,    dst_sq: 1'b0, cond: C_NEVER,       target: ST_IDLE};
			ST_CHK:   u = '{op: OP_NOP,    dst_sq: 1'b0, cond: C_E_ZERO,      target: ST_FIN};
			ST_BIT:   u = '{op: OP_NOP,    dst_sq: 1'b0, cond: C_BIT0_CLR,    target: ST_SHIFT};
			ST_MR_LO: u = '{op: OP_MUL_LO, dst_sq: 1'b0, cond: C_NARROW,      target: ST_SHIFT};
			ST_MR_HI: u = '{op: OP_MUL_HI, dst_sq: 1'b0, cond: C_NEVER,       target: ST_IDLE};
			ST_SHIFT: u = '{op: OP_SHIFT,  dst_sq: 1'b0, cond: C_E_LAST,      target: ST_FIN};
			ST_MS_LO: u = '{op: OP_MUL_LO, dst_sq: 1'b1, cond: C_NARROW,      target: ST_BIT};
			ST_MS_HI: u = '{op: OP_MUL_HI, dst_sq: 1'b1, cond: C_ALWAYS,      target: ST_BIT};
			ST_FIN:   u = '{op: OP_EMIT,   dst_sq: 1'b0, cond: C_OUT_BLOCKED, target: ST_FIN};
			default:  u = '{op: OP_NOP,    dst_sq: 1'b0, cond: C_ALWAYS,      target: ST_IDLE};
		endcase
		return u;
	endfunction

	function automatic poly_t field_poly(input deg_t m);
		poly_t p;
		p = 17'o7;
		case (m)
			5'd2:    p = 17'o7;
			5'd3:    p = 17'o13;
			5'd4:    p = 17'o23;
			5'd5:    p = 17'o45;
			5'd6:    p = 17'o103;
			5'd7:    p = 17'o203;
			5'd8:    p = 17'o435;
			5'd9:    p = 17'o1041;
			5'd10:   p = 17'o2011;
			5'd11:   p = 17'o4005;
			5'd12:   p = 17'o10123;
			5'd13:   p = 17'o20033;
			5'd14:   p = 17'o42103;
			5'd15:   p = 17'o100003;
			5'd16:   p = 17'o210013;
			default: p = 17'o7;
		endcase
		return p;
	endfunction

endpackage

>>> rtl/gfp_req_if.sv
`timescale 1ns / 1ps

interface gfp_req_if;
	logic            valid;
	logic            ready;
	gfp_pkg::elem_t  base;
	gfp_pkg::exp_t   exponent;

	modport source (output valid, base, exponent, input ready);
	modport sink   (input valid, base, exponent, output ready);
endinterface

>>> rtl/gfp_rsp_if.sv
`timescale 1ns / 1ps

interface gfp_rsp_if;
	logic            valid;
	logic            ready;
	gfp_pkg::elem_t  power;

	modport source (output valid, power, input ready);
	modport sink   (input valid, power, output ready);
endinterface

>>> rtl/gfp_mul.sv
`timescale 1ns / 1ps

// one digit of a shift-and-add field multiply
module gfp_mul (
	input  gfp_pkg::deg_t   m,
	input  gfp_pkg::poly_t  poly,
	input  gfp_pkg::elem_t  acc_in,
	input  gfp_pkg::elem_t  a_in,
	input  gfp_pkg::digit_t digit,
	output gfp_pkg::elem_t  acc_out,
	output gfp_pkg::elem_t  a_out
);

	always_comb begin
		gfp_pkg::elem_t acc;
		gfp_pkg::poly_t a;
		acc = acc_in;
		a   = {1'b0, a_in};
		for (int k = 0; k < gfp_pkg::DIGIT_W; k++) begin
			if (digit[k]) begin
				acc = acc ^ a[gfp_pkg::ELEM_W-1:0];
			end
			a = {a[gfp_pkg::POLY_W-2:0], 1'b0};
			if (a[m]) begin
				a = a ^ poly;
			end
		end
		acc_out = acc;
		a_out   = a[gfp_pkg::ELEM_W-1:0];
	end

endmodule

>>> rtl/gfp_dp.sv
`timescale 1ns / 1ps

module gfp_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  gfp_pkg::ctl_t   ctl,
	input  gfp_pkg::deg_t   m,
	input  gfp_pkg::poly_t  poly,
	input  logic            req_valid,
	input  gfp_pkg::elem_t  base,
	input  gfp_pkg::exp_t   exponent,
	input  logic            rsp_ready,
	output logic            rsp_valid,
	output gfp_pkg::elem_t  power,
	output gfp_pkg::stat_t  stat
);

	gfp_pkg::elem_t res_q, sq_q, acc_q, ap_q, power_q;
	gfp_pkg::exp_t  e_q;
	logic           out_valid_q;

	gfp_pkg::poly_t mask_w;
	gfp_pkg::elem_t mask;
	gfp_pkg::exp_t  e_hi, e_lo, fold_sum;
	gfp_pkg::elem_t opa, mul_acc_in, mul_a_in, mul_acc, mul_a;
	gfp_pkg::digit_t mul_digit;
	logic           is_hi, narrow, blocked;

	assign mask_w   = (gfp_pkg::POLY_W'(1) << m) - gfp_pkg::POLY_W'(1);
	assign mask     = mask_w[gfp_pkg::ELEM_W-1:0];
	assign e_hi     = e_q >> m;
	assign e_lo     = e_q & gfp_pkg::EXP_W'(mask);
	assign fold_sum = e_hi + e_lo;
	assign narrow   = (m <= gfp_pkg::DEG_NARROW);
	assign blocked  = out_valid_q && !rsp_ready;

	assign is_hi      = (ctl.op == gfp_pkg::OP_MUL_HI);
	assign opa        = ctl.dst_sq ? sq_q : res_q;
	assign mul_acc_in = is_hi ? acc_q : '0;
	assign mul_a_in   = is_hi ? ap_q : opa;
	assign mul_digit  = is_hi ? sq_q[gfp_pkg::ELEM_W-1:gfp_pkg::DIGIT_W]
	                          : sq_q[gfp_pkg::DIGIT_W-1:0];

	gfp_mul u_mul (
		.m       (m),
		.poly    (poly),
		.acc_in  (mul_acc_in),
		.a_in    (mul_a_in),
		.digit   (mul_digit),
		.acc_out (mul_acc),
		.a_out   (mul_a)
	);

	always_ff @(posedge clk) begin
		case (ctl.op)
			gfp_pkg::OP_LOAD: begin
				if (req_valid) begin
					e_q   <= exponent;
					sq_q  <= base & mask;
					res_q <= gfp_pkg::ELEM_W'(1);
				end
			end
			gfp_pkg::OP_XRES: begin
				res_q <= (sq_q == '0) ? '0 : gfp_pkg::ELEM_W'(1);
			end
			gfp_pkg::OP_FOLD: begin
				e_q <= fold_sum;
			end
			gfp_pkg::OP_FIX: begin
				if (e_q == gfp_pkg::EXP_W'(mask)) begin
					e_q <= '0;
				end
			end
			gfp_pkg::OP_MUL_LO: begin
				acc_q <= mul_acc;
				ap_q  <= mul_a;
				if (narrow) begin
					if (ctl.dst_sq) begin
						sq_q <= mul_acc;
					end else begin
						res_q <= mul_acc;
					end
				end
			end
			gfp_pkg::OP_MUL_HI: begin
				if (ctl.dst_sq) begin
					sq_q <= mul_acc;
				end else begin
					res_q <= mul_acc;
				end
			end
			gfp_pkg::OP_SHIFT: begin
				e_q <= e_q >> 1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.op == gfp_pkg::OP_EMIT && !blocked) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == gfp_pkg::OP_EMIT && !blocked) begin
			power_q <= res_q & mask;
		end
	end

	assign rsp_valid = out_valid_q;
	assign power     = power_q;

	assign stat.e_zero      = (e_q == '0);
	assign stat.x_zero      = (sq_q == '0);
	assign stat.e_wide      = (e_hi != '0);
	assign stat.bit0_clr    = !e_q[0];
	assign stat.e_last      = (e_q[gfp_pkg::EXP_W-1:1] == '0);
	assign stat.narrow      = narrow;
	assign stat.out_blocked = blocked;

endmodule

>>> rtl/gfp_seq.sv
`timescale 1ns / 1ps

module gfp_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  gfp_pkg::stat_t stat,
	output gfp_pkg::ctl_t  ctl,
	output logic           idle
);

	gfp_pkg::pc_t    pc_q, pc_next;
	gfp_pkg::ucode_t uc;
	logic            take;

	assign uc = gfp_pkg::ucode(pc_q);

	always_comb begin
		case (uc.cond)
			gfp_pkg::C_NEVER:       take = 1'b0;
			gfp_pkg::C_ALWAYS:      take = 1'b1;
			gfp_pkg::C_NO_REQ:      take = !req_valid;
			gfp_pkg::C_E_ZERO:      take = stat.e_zero;
			gfp_pkg::C_X_ZERO:      take = stat.x_zero;
			gfp_pkg::C_E_WIDE:      take = stat.e_wide;
			gfp_pkg::C_BIT0_CLR:    take = stat.bit0_clr;
			gfp_pkg::C_NARROW:      take = stat.narrow;
			gfp_pkg::C_E_LAST:      take = stat.e_last;
			gfp_pkg::C_OUT_BLOCKED: take = stat.out_blocked;
			default:                take = 1'b1;
		endcase
	end

	always_comb begin
		if (take) begin
			pc_next = uc.target;
		end else if (pc_q == gfp_pkg::PROG_LAST) begin
			pc_next = gfp_pkg::ST_IDLE;
		end else begin
			pc_next = pc_q + gfp_pkg::PC_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= gfp_pkg::ST_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

	assign ctl.op     = uc.op;
	assign ctl.dst_sq = uc.dst_sq;
	assign idle       = (pc_q == gfp_pkg::ST_IDLE);

endmodule

>>> rtl/gf2m_power.sv
`timescale 1ns / 1ps

// gf2m_power: x**e in GF(2^m), m set by cfg_wdata (2..16, reset 8).
// req carries base and exponent; rsp returns power, both valid/ready.
// A request is taken only while the sequencer sits at its idle step;
// one request is in work at a time.
// From request to result: fold passes reduce the exponent mod 2^m-1
// (one m-bit add per cycle), then per exponent bit one test, one
// shift and up to two field products on the single shared multiplier;
// each product uses the low-digit step alone for m <= 8 and the low-
// and high-digit steps for m > 8. A zero exponent or a zero base goes
// straight to the final step.
// The result lands in an output register; the sequencer holds at its
// final step while that register is full and rsp.ready is low, and the
// next request is taken once the result has moved into it.
// Reset clears the sequencer and the output valid and sets m to 8.
// cfg writes are allowed only while no request is in flight.
module gf2m_power (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  gfp_pkg::deg_t     cfg_wdata,
	gfp_req_if.sink           req,
	gfp_rsp_if.source         rsp
);

	gfp_pkg::deg_t  ext_degree_q;
	gfp_pkg::deg_t  m;
	gfp_pkg::poly_t poly;
	gfp_pkg::ctl_t  ctl;
	gfp_pkg::stat_t stat;
	logic           idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_degree_q <= gfp_pkg::DEG_RESET;
		end else if (cfg_we) begin
			ext_degree_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (ext_degree_q < gfp_pkg::DEG_W'(gfp_pkg::MIN_DEGREE)) begin
			m = gfp_pkg::DEG_W'(gfp_pkg::MIN_DEGREE);
		end else if (ext_degree_q > gfp_pkg::DEG_W'(gfp_pkg::MAX_DEGREE)) begin
			m = gfp_pkg::DEG_W'(gfp_pkg::MAX_DEGREE);
		end else begin
			m = ext_degree_q;
		end
	end

	assign poly      = gfp_pkg::field_poly(m);
	assign req.ready = idle;

	gfp_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.stat      (stat),
		.ctl       (ctl),
		.idle      (idle)
	);

	gfp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.m         (m),
		.poly      (poly),
		.req_valid (req.valid),
		.base      (req.base),
		.exponent  (req.exponent),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.power     (rsp.power),
		.stat      (stat)
	);

`ifndef SYNTHESIS
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("sequencer stayed idle after taking a request");

	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(req.ready) |-> $past(req.valid))
		else $error("request ready dropped without a request");

	a_power_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> ((32'(rsp.power) >> m) == 32'd0))
		else $error("result has bits at or above the field degree");
`endif

endmodule
